>>> hdl/spq_pkg.sv
package spq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 8;

	localparam int VALUE_W  = 32;
	localparam int PRIO_IN_W = 8;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;
	localparam int IDX_W    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W  = VALUE_W + PRIORITY_BITS;

	localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [PRIORITY_BITS-1:0] prio_t;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_REMOVE = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [VALUE_W-1:0]  value;
		logic [PRIO_IN_W-1:0]       priority_req;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic signed [VALUE_W-1:0]  removed_value;
		logic [OCC_W-1:0]           occupancy;
	} rsp_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		prio_t              prio;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REM,
		S_INS,
		S_INS_HEAD,
		S_PUSH
	} state_t;

	// Map a position in service order to a slot of the circular store.
	function automatic idx_t phys(input idx_t head, input idx_t ofs);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, ofs};
		if (sum >= (IDX_W+1)'(QUEUE_DEPTH))
			sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
		return sum[IDX_W-1:0];
	endfunction

endpackage

>>> hdl/stable_priority_queue.sv
// Bounded priority queue, highest priority served first and equal priorities in
// arrival order. Entries sit in one circular memory in service order, so a
// remove reads the head and advances the head pointer, passing through the
// remove and push states on its way to the output register. An insert walks
// from the tail towards the head, moving each lower-priority entry one slot
// back through the single write port, one entry a cycle. An insert into an
// empty queue, a remove from an empty queue and an insert into a full one go
// straight to the push state. The push state repeats for as long as the
// output register holds a stalled result. One request is in progress at a
// time; the next is taken once the previous result has moved to the output
// register, which may still be waiting to be taken.
module stable_priority_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  spq_pkg::req_t      req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output spq_pkg::rsp_t      rsp
);

	spq_pkg::state_t state_q, state_d;
	spq_pkg::cnt_t   count_q;
	spq_pkg::idx_t   head_q;
	spq_pkg::idx_t   pos_q;
	spq_pkg::entry_t new_q;
	spq_pkg::rsp_t   res_q;
	spq_pkg::rsp_t   out_q;
	logic            out_valid_q;

	logic            accept;
	logic            out_free;
	logic            is_remove;
	logic            is_empty;
	logic            is_full;
	logic            ins_stop;
	logic            at_head;
	spq_pkg::prio_t  req_prio;
	spq_pkg::idx_t   last_idx;
	spq_pkg::cnt_t   count_inc;
	spq_pkg::cnt_t   count_dec;

	logic                         wr_en;
	spq_pkg::idx_t                wr_addr;
	spq_pkg::entry_t              wr_data;
	logic                         rd_en;
	spq_pkg::idx_t                rd_addr;
	logic [spq_pkg::ENTRY_W-1:0]  rd_data;
	spq_pkg::entry_t              rd_entry;

	assign req_stall = (state_q != spq_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign is_remove = (req.kind == spq_pkg::KIND_REMOVE);
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
	assign req_prio  = spq_pkg::PRIORITY_BITS'(req.priority_req);
	assign count_inc = count_q + spq_pkg::CNT_W'(1);
	assign count_dec = count_q - spq_pkg::CNT_W'(1);
	assign last_idx  = spq_pkg::IDX_W'(count_dec);

	assign rd_entry  = rd_data;
	assign ins_stop  = (rd_entry.prio >= new_q.prio);
	assign at_head   = (pos_q == '0);

	spq_ram #(
		.WIDTH (spq_pkg::ENTRY_W),
		.DEPTH (spq_pkg::QUEUE_DEPTH)
	) u_entries (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept) begin
					if (is_remove)
						state_d = is_empty ? spq_pkg::S_PUSH : spq_pkg::S_REM;
					else if (is_full || is_empty)
						state_d = spq_pkg::S_PUSH;
					else
						state_d = spq_pkg::S_INS;
				end
			end
			spq_pkg::S_REM:      state_d = spq_pkg::S_PUSH;
			spq_pkg::S_INS: begin
				if (ins_stop)
					state_d = spq_pkg::S_PUSH;
				else if (at_head)
					state_d = spq_pkg::S_INS_HEAD;
			end
			spq_pkg::S_INS_HEAD: state_d = spq_pkg::S_PUSH;
			spq_pkg::S_PUSH: begin
				if (out_free)
					state_d = spq_pkg::S_IDLE;
			end
			default:             state_d = spq_pkg::S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = new_q;
		rd_en   = 1'b0;
		rd_addr = head_q;
		case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept && is_remove && !is_empty) begin
					rd_en   = 1'b1;
					rd_addr = head_q;
				end else if (accept && !is_remove && !is_full) begin
					if (is_empty) begin
						wr_en   = 1'b1;
						wr_addr = head_q;
						wr_data = '{value: req.value, prio: req_prio};
					end else begin
						rd_en   = 1'b1;
						rd_addr = spq_pkg::phys(head_q, last_idx);
					end
				end
			end
			spq_pkg::S_INS: begin
				// place the new entry behind this one, or move this one back a slot
				wr_en   = 1'b1;
				wr_addr = spq_pkg::phys(head_q, pos_q + spq_pkg::IDX_W'(1));
				wr_data = ins_stop ? new_q : rd_entry;
				if (!ins_stop && !at_head) begin
					rd_en   = 1'b1;
					rd_addr = spq_pkg::phys(head_q, pos_q - spq_pkg::IDX_W'(1));
				end
			end
			spq_pkg::S_INS_HEAD: begin
				wr_en   = 1'b1;
				wr_addr = head_q;
				wr_data = new_q;
			end
			default: begin
				wr_en = 1'b0;
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				spq_pkg::S_IDLE: begin
					if (accept && !is_remove && is_empty)
						count_q <= count_inc;
				end
				spq_pkg::S_REM: begin
					count_q <= count_dec;
					head_q  <= spq_pkg::phys(head_q, spq_pkg::IDX_W'(1));
				end
				spq_pkg::S_INS: begin
					if (ins_stop)
						count_q <= count_inc;
				end
				spq_pkg::S_INS_HEAD: count_q <= count_inc;
				default: begin
					count_q <= count_q;
				end
			endcase
			if (state_q == spq_pkg::S_PUSH && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept) begin
					new_q <= '{value: req.value, prio: req_prio};
					pos_q <= last_idx;
					if (is_remove)
						res_q <= '{status: spq_pkg::ST_EMPTY,
							removed_value: spq_pkg::EMPTY_VALUE,
							occupancy: spq_pkg::OCC_W'(count_q)};
					else if (is_full)
						res_q <= '{status: spq_pkg::ST_FULL, removed_value: '0,
							occupancy: spq_pkg::OCC_W'(count_q)};
					else
						res_q <= '{status: spq_pkg::ST_OK, removed_value: '0,
							occupancy: spq_pkg::OCC_W'(count_inc)};
				end
			end
			spq_pkg::S_REM: begin
				res_q <= '{status: spq_pkg::ST_OK, removed_value: rd_entry.value,
					occupancy: spq_pkg::OCC_W'(count_dec)};
			end
			spq_pkg::S_INS: begin
				if (!ins_stop && !at_head)
					pos_q <= pos_q - spq_pkg::IDX_W'(1);
			end
			spq_pkg::S_PUSH: begin
				if (out_free)
					out_q <= res_q;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en && wr_addr == rd_addr))
		else $error("read and write of the same slot in one cycle");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::S_REM |=> count_q == ($past(count_q) - spq_pkg::CNT_W'(1)))
		else $error("remove did not drop the entry count");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spq_pkg::S_PUSH && out_free) |=>
			(rsp_valid && state_q == spq_pkg::S_IDLE))
		else $error("result not moved to the output register");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_remove && !is_full && !is_empty) |=>
			(req_stall && state_q == spq_pkg::S_INS))
		else $error("insert walk not started");

endmodule

>>> hdl/spq_ram.sv
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

>>> sim/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  spq_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  spq_pkg::rsp_t rsp,
	output int            fail_count,
	output int            replies_due
);

	spq_pkg::entry_t held[$];
	spq_pkg::rsp_t   due_replies[$];
	int              faults;

	// Apply one request to the queue image and return the reply it should get.
	function automatic spq_pkg::rsp_t serve(input spq_pkg::req_t r);
		spq_pkg::rsp_t   res;
		spq_pkg::entry_t e;
		int              pos;
		res.status        = spq_pkg::ST_OK;
		res.removed_value = '0;
		if (r.kind == spq_pkg::KIND_INSERT) begin
			if (held.size() >= spq_pkg::QUEUE_DEPTH) begin
				res.status = spq_pkg::ST_FULL;
			end else begin
				e.value = r.value;
				e.prio  = spq_pkg::prio_t'(r.priority_req);
				pos = 0;
				// land behind every entry of equal or higher priority
				while (pos < held.size() && held[pos].prio >= e.prio)
					pos++;
				held.insert(pos, e);
			end
		end else begin
			if (held.size() == 0) begin
				res.status        = spq_pkg::ST_EMPTY;
				res.removed_value = spq_pkg::EMPTY_VALUE;
			end else begin
				e = held.pop_front();
				res.removed_value = e.value;
			end
		end
		res.occupancy = spq_pkg::OCC_W'(held.size());
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		spq_pkg::rsp_t want;
		if (!arst_n) begin
			held.delete();
			due_replies.delete();
			faults = 0;
			fail_count  <= 0;
			replies_due <= 0;
		end else begin
			if (req_valid && !req_stall)
				due_replies.push_back(serve(req));
			if (rsp_valid && !rsp_stall) begin
				if (due_replies.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("%0t: stray reply: status %0d value %0d occ %0d",
							$realtime, rsp.status, rsp.removed_value, rsp.occupancy);
				end else begin
					want = due_replies.pop_front();
					if (rsp.status !== want.status || rsp.removed_value !== want.removed_value
							|| rsp.occupancy !== want.occupancy) begin
						faults++;
						if (faults <= 10)
							$display("%0t: want/got status %0d/%0d value %0d/%0d occ %0d/%0d",
								$realtime, want.status, rsp.status, want.removed_value,
								rsp.removed_value, want.occupancy, rsp.occupancy);
					end
				end
			end
			fail_count  <= faults;
			replies_due <= due_replies.size();
		end
	end

endmodule

>>> sim/stable_priority_queue_test.sv
`timescale 1ns / 1ps

module stable_priority_queue_test;

	localparam int RAND_ITEMS = 1250;
	localparam int CALM_ITEMS = 150;
	localparam int IDLE_LIMIT = 2000;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          rsp_stall = 1'b0;
	spq_pkg::req_t req       = '0;
	logic          req_stall;
	logic          rsp_valid;
	spq_pkg::rsp_t rsp;

	logic quiet     = 1'b0;
	int   stall_left = 0;
	int   idle_cycles = 0;
	int   fail_count;
	int   replies_due;

	logic signed [spq_pkg::VALUE_W-1:0] fill_values[16] = '{
		32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd5, 32'sd6, 32'sd7, 32'sd8,
		32'sd9, 32'sd10, 32'sd11, 32'sh5a5a5a5a, 32'sha5a5a5a5, 32'sd14, 32'sd15, 32'sd16
	};
	logic [spq_pkg::PRIO_IN_W-1:0] fill_prios[16] = '{
		8'd255, 8'd0, 8'd255, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255,
		8'd1, 8'd254, 8'd128, 8'd0, 8'd255, 8'd64, 8'd64, 8'd200
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stable_priority_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	spq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.replies_due (replies_due)
	);

	// Receiver: stall bursts between free stretches.
	always @(posedge clk) begin
		if (quiet) begin
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 8);
		end else begin
			rsp_stall  <= 1'b0;
			stall_left <= $urandom_range(0, 19);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic spq_pkg::req_t make_request(input spq_pkg::kind_t k,
			input logic signed [spq_pkg::VALUE_W-1:0] v,
			input logic [spq_pkg::PRIO_IN_W-1:0] p);
		spq_pkg::req_t r;
		r.kind         = k;
		r.value        = v;
		r.priority_req = p;
		return r;
	endfunction

	// Present one request, after an optional idle burst, and hold it until taken.
	task automatic send_request(input spq_pkg::req_t r, input int gap_odds);
		if (!quiet && gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	initial begin : stimulus
		int                                 insert_pct;
		int                                 gap_odds;
		int                                 prio_mode;
		logic signed [spq_pkg::VALUE_W-1:0] v;
		logic [spq_pkg::PRIO_IN_W-1:0]      p;
		spq_pkg::kind_t                     k;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty remove, fill to the brim with ties and extremes, overflow, partial drain
		send_request(make_request(spq_pkg::KIND_REMOVE, $urandom,
			spq_pkg::PRIO_IN_W'($urandom)), 3);
		for (int n = 0; n < 16; n++)
			send_request(make_request(spq_pkg::KIND_INSERT, fill_values[n], fill_prios[n]), 3);
		send_request(make_request(spq_pkg::KIND_INSERT, 32'sd123, 8'd255), 3);
		for (int n = 0; n < 6; n++)
			send_request(make_request(spq_pkg::KIND_REMOVE, $urandom,
				spq_pkg::PRIO_IN_W'($urandom)), 3);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0:       insert_pct = 25;
					1:       insert_pct = 50;
					default: insert_pct = 80;
				endcase
				gap_odds  = $urandom_range(0, 1) ? 0 : 3;
				prio_mode = $urandom_range(0, 2);
			end
			if (n == RAND_ITEMS - CALM_ITEMS)
				quiet <= 1'b1;
			k = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::KIND_INSERT
				: spq_pkg::KIND_REMOVE;
			v = $urandom;
			if ($urandom_range(0, 15) == 0)
				v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			// narrow priority sets make ties common
			case (prio_mode)
				0:       p = spq_pkg::PRIO_IN_W'($urandom);
				1:       p = spq_pkg::PRIO_IN_W'($urandom_range(0, 3));
				default: p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			endcase
			send_request(make_request(k, v, p), gap_odds);
		end
		req_valid <= 1'b0;

		do @(posedge clk); while (replies_due != 0);
		repeat (24) @(posedge clk);

		if (fail_count == 0 && replies_due == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
